/* rtl/fft_magnitude_spectrum_top_macros.svh */
// Assertion macros shared by the RTL.
`ifndef FFT_MAGNITUDE_SPECTRUM_TOP_MACROS_SVH
`define FFT_MAGNITUDE_SPECTRUM_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define FMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define FMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fms_pkg.sv */
`default_nettype none
package fms_pkg;

  localparam int unsigned VREF_MV = 3290;
  localparam int unsigned ADC_FULL = 65535;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam int unsigned LOG2_RESET = 10;
  localparam int unsigned MAG_MAX = 32'h3FFF_FFFF;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic REG_LOG2_POINTS = 1'b0;
  localparam logic REG_WINDOW_ENABLE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] sample;
    logic [9:0]  bin_index;
  } in_item_t;

  typedef struct packed {
    logic [29:0] magnitude;
    logic [9:0]  bin_echo;
    logic        ready_res;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_MUL,
    S_LD_WR,
    S_LD_DC,
    S_WN_RD,
    S_WN_SUB,
    S_WN_MUL,
    S_WN_WR,
    S_BF_RB,
    S_BF_RA,
    S_BF_M1,
    S_BF_M2,
    S_BF_M3,
    S_BF_M4,
    S_BF_M5,
    S_BF_WA,
    S_BF_WB,
    S_RD_RD,
    S_RD_SQ1,
    S_RD_SQ2,
    S_RD_SQ3,
    S_RD_ROOT,
    S_RD_FIN
  } fms_state_t;

endpackage
`default_nettype wire

/* rtl/fft_magnitude_spectrum_top.sv */
// Channel   Ports                                  Direction  Handshake
// input     start, busy, in_item                   in         start & !busy
// result    out_valid, out_item                    out        one-cycle strobe
// config    psel penable pwrite paddr pwdata ...   in/out     APB, pready tied high
//
// A load beat is busy through its multiply and memory write; the beat that ends a frame
// adds the transform (DC removal, the optional Hann window, the butterflies), set by one
// shared multiplier and the one-read/one-write sample memories.
// A read beat that hits is busy through the bin read, the squares and the bit-serial square root;
// a miss is busy only for the result. The result strobe rises at the edge that drops busy.
// Reset (rst_n low, synchronous) empties the frame and restores the registers.
// The result side never stalls.
`default_nettype none
`include "fft_magnitude_spectrum_top_macros.svh"
module fft_magnitude_spectrum_top #(
  parameter int MAX_POINTS = 1024,
  parameter int TWIDDLE_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire fms_pkg::in_item_t in_item,
  output logic                out_valid,
  output fms_pkg::out_item_t  out_item,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fms_pkg::*;

  localparam int L = $clog2(MAX_POINTS);
  localparam int AW = L;
  localparam int SW = $clog2(L + 1);
  localparam int TB = TWIDDLE_BITS;
  localparam int ROM_COS = 0;
  localparam int ROM_SIN = 1;
  localparam int ROM_HANN = 2;

  typedef logic signed [TB-1:0] rom_t [MAX_POINTS];

  function automatic logic signed [TB-1:0] rom_value(input longint q30);
    longint t;
    longint hi;
    longint lo;
    begin
      t = (q30 + (64'sd1 <<< (30 - TB))) >>> (31 - TB);
      hi = (64'sd1 <<< (TB - 1)) - 1;
      lo = -(64'sd1 <<< (TB - 1));
      if (t > hi) t = hi;
      if (t < lo) t = lo;
      return t[TB-1:0];
    end
  endfunction

  function automatic rom_t build_rom(input int sel);
    rom_t rom;
    longint unsigned r4, th, t2, term, nx;
    longint s, c, cv, sv, h;
    int quad;
    begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        quad = (4 * k) / MAX_POINTS;
        r4 = 64'((4 * k) % MAX_POINTS);
        th = (PI_Q30 * r4) / (2 * MAX_POINTS);
        t2 = (th * th) >> 30;
        s = 0;
        c = 0;
        term = th;
        for (int i = 0; i < 10; i++) begin
          if (i % 2 == 1) s = s - longint'(term); else s = s + longint'(term);
          nx = (term * t2) >> 30;
          case (i)
            0: term = nx / 6;
            1: term = nx / 20;
            2: term = nx / 42;
            3: term = nx / 72;
            4: term = nx / 110;
            5: term = nx / 156;
            6: term = nx / 210;
            7: term = nx / 272;
            8: term = nx / 342;
            default: term = nx / 420;
          endcase
        end
        term = 64'(ONE_Q30);
        for (int i = 0; i < 10; i++) begin
          if (i % 2 == 1) c = c - longint'(term); else c = c + longint'(term);
          nx = (term * t2) >> 30;
          case (i)
            0: term = nx / 2;
            1: term = nx / 12;
            2: term = nx / 30;
            3: term = nx / 56;
            4: term = nx / 90;
            5: term = nx / 132;
            6: term = nx / 182;
            7: term = nx / 240;
            8: term = nx / 306;
            default: term = nx / 380;
          endcase
        end
        case (quad % 4)
          0: begin cv = c; sv = s; end
          1: begin cv = -s; sv = c; end
          2: begin cv = -c; sv = -s; end
          default: begin cv = s; sv = -c; end
        endcase
        h = ONE_Q30 - cv;
        if (h < 0) h = 0;
        if (sel == ROM_COS) rom[k] = rom_value(cv);
        else if (sel == ROM_SIN) rom[k] = rom_value(sv);
        else rom[k] = rom_value(h >>> 1);
      end
      return rom;
    end
  endfunction

  localparam rom_t COS_ROM = build_rom(ROM_COS);
  localparam rom_t SIN_ROM = build_rom(ROM_SIN);
  localparam rom_t HANN_ROM = build_rom(ROM_HANN);

  function automatic logic [AW-1:0] rev_addr(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    begin
      for (int b = 0; b < AW; b++) r[b] = a[AW-1-b];
      return r;
    end
  endfunction

  function automatic logic signed [65:0] rnd_tw(input logic signed [65:0] v);
    return (v + (66'sd1 <<< (TB - 2))) >>> (TB - 1);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    else if (v < -66'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  // sample memories
  logic signed [31:0] re_mem [MAX_POINTS];
  logic signed [31:0] im_mem [MAX_POINTS];
  logic signed [31:0] re_q, im_q;

  fms_state_t state_r, state_nxt;

  logic [3:0]      log2_points_r;
  logic            window_enable_r;
  logic [21:0]     sum_r;
  logic [L:0]      cnt_r;
  logic            valid_r;
  logic [30:0]     dc_r;
  in_item_t        in_r;
  logic [27:0]     mvp_r;
  logic [AW-1:0]   wcnt_r;
  logic [AW-1:0]   j_r;
  logic [SW-1:0]   s_r;
  logic signed [32:0] x_r;
  logic signed [TB-1:0] hann_q, cos_q, sin_q;
  logic signed [31:0] br_r, bi_r, ar_r, ai_r;
  logic signed [65:0] mul_r, acc_r, tr_r, ti_r;
  logic            hit_r;
  logic [63:0]     rem_r, root_r, bit_r;
  logic [4:0]      rcnt_r;
  logic            out_valid_r;
  out_item_t       out_item_r;

  // control and datapath decode
  logic [SW-1:0]   lg;
  logic [L:0]      n_pts;
  logic            accept, cfg_wr;
  logic            rd_en, re_we, im_we;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic signed [31:0] wr_re, wr_im;
  logic signed [32:0] mul_a, mul_b;
  logic [AW-1:0]   hmask, ia, ib, tw_idx, ld_addr;
  logic [11:0]     mv;
  logic [16:0]     mv_rem;
  logic signed [65:0] ti_rnd;
  logic            frame_last, wn_last, bf_last, stage_last, root_take;
  logic [63:0]     root_try;
  logic [32:0]     root_fin;

  always_comb begin
    if (log2_points_r == 4'd0) lg = SW'(1);
    else if (int'(log2_points_r) > L) lg = SW'(L);
    else lg = SW'(log2_points_r);
  end

  assign n_pts = (L+1)'(1) << lg;
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy = (state_r != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_ENABLE) ? 32'(window_enable_r) : 32'(log2_points_r);
  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

  assign mv_rem = 17'(mvp_r[15:0]) + 17'(mvp_r[27:16]);
  assign mv = mvp_r[27:16] + 12'(mv_rem >= 17'(ADC_FULL));
  assign ld_addr = rev_addr(cnt_r[AW-1:0]) >> (L - int'(lg));
  assign frame_last = ((cnt_r + 1'b1) == n_pts);
  assign wn_last = ((L+1)'(wcnt_r) == n_pts - 1'b1);
  assign bf_last = ((L+1)'(j_r) == (n_pts >> 1) - 1'b1);
  assign stage_last = (s_r == lg);

  assign hmask = (AW'(1) << (s_r - 1'b1)) - 1'b1;
  assign ia = ((j_r & ~hmask) << 1) | (j_r & hmask);
  assign ib = ia | (hmask + 1'b1);
  assign tw_idx = (j_r & hmask) << (L - int'(s_r));
  assign ti_rnd = rnd_tw(acc_r);

  assign root_try = root_r + bit_r;
  assign root_take = (rem_r >= root_try);
  assign root_fin = 33'(root_r) + 33'(rem_r > root_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.mode == MODE_LOAD) state_nxt = S_LD_MUL;
          else if (valid_r && (13'(in_item.bin_index) < 13'(n_pts))) state_nxt = S_RD_RD;
          else state_nxt = S_RD_FIN;
        end
      end
      S_LD_MUL:  state_nxt = S_LD_WR;
      S_LD_WR:   state_nxt = frame_last ? S_LD_DC : S_IDLE;
      S_LD_DC:   state_nxt = S_WN_RD;
      S_WN_RD:   state_nxt = S_WN_SUB;
      S_WN_SUB:  state_nxt = window_enable_r ? S_WN_MUL : S_WN_WR;
      S_WN_MUL:  state_nxt = S_WN_WR;
      S_WN_WR:   state_nxt = wn_last ? S_BF_RB : S_WN_RD;
      S_BF_RB:   state_nxt = S_BF_RA;
      S_BF_RA:   state_nxt = S_BF_M1;
      S_BF_M1:   state_nxt = S_BF_M2;
      S_BF_M2:   state_nxt = S_BF_M3;
      S_BF_M3:   state_nxt = S_BF_M4;
      S_BF_M4:   state_nxt = S_BF_M5;
      S_BF_M5:   state_nxt = S_BF_WA;
      S_BF_WA:   state_nxt = S_BF_WB;
      S_BF_WB:   state_nxt = (bf_last && stage_last) ? S_IDLE : S_BF_RB;
      S_RD_RD:   state_nxt = S_RD_SQ1;
      S_RD_SQ1:  state_nxt = S_RD_SQ2;
      S_RD_SQ2:  state_nxt = S_RD_SQ3;
      S_RD_SQ3:  state_nxt = S_RD_ROOT;
      S_RD_ROOT: state_nxt = (rcnt_r == 5'd31) ? S_RD_FIN : S_RD_ROOT;
      S_RD_FIN:  state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // memory and multiplier control
  always_comb begin
    rd_en = 1'b0;
    rd_addr = ia;
    re_we = 1'b0;
    im_we = 1'b0;
    wr_addr = ia;
    wr_re = sat32(66'(ar_r) + tr_r);
    wr_im = sat32(66'(ai_r) + ti_rnd);
    mul_a = 33'(cos_q);
    mul_b = 33'(br_r);
    unique case (state_r)
      S_LD_WR: begin
        re_we = 1'b1;
        wr_addr = ld_addr;
        wr_re = {12'd0, mv, 8'd0};
      end
      S_WN_RD: begin
        rd_en = 1'b1;
        rd_addr = wcnt_r;
      end
      S_WN_MUL: begin
        mul_a = x_r;
        mul_b = 33'(hann_q);
      end
      S_WN_WR: begin
        re_we = 1'b1;
        im_we = 1'b1;
        wr_addr = wcnt_r;
        wr_re = window_enable_r ? sat32(rnd_tw(mul_r)) : sat32(66'(x_r));
        wr_im = 32'sd0;
      end
      S_BF_RB: begin
        rd_en = 1'b1;
        rd_addr = ib;
      end
      S_BF_RA: rd_en = 1'b1;
      S_BF_M2: begin
        mul_a = 33'(sin_q);
        mul_b = 33'(bi_r);
      end
      S_BF_M3: mul_b = 33'(bi_r);
      S_BF_M4: mul_a = 33'(sin_q);
      S_BF_WA: begin
        re_we = 1'b1;
        im_we = 1'b1;
      end
      S_BF_WB: begin
        re_we = 1'b1;
        im_we = 1'b1;
        wr_addr = ib;
        wr_re = sat32(66'(ar_r) - tr_r);
        wr_im = sat32(66'(ai_r) - ti_r);
      end
      S_RD_RD: begin
        rd_en = 1'b1;
        rd_addr = AW'(in_r.bin_index);
      end
      S_RD_SQ1: begin
        mul_a = 33'(re_q);
        mul_b = 33'(re_q);
      end
      S_RD_SQ2: begin
        mul_a = 33'(im_q);
        mul_b = 33'(im_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      re_q <= re_mem[rd_addr];
      im_q <= im_mem[rd_addr];
    end
    if (re_we) re_mem[wr_addr] <= wr_re;
    if (im_we) im_mem[wr_addr] <= wr_im;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      log2_points_r <= 4'(LOG2_RESET);
      window_enable_r <= 1'b0;
      sum_r <= '0;
      cnt_r <= '0;
      valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      wcnt_r <= '0;
      j_r <= '0;
      s_r <= SW'(1);
      rcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= (state_r == S_RD_FIN);
      if (cfg_wr) begin
        if (paddr[2] == REG_LOG2_POINTS) begin
          log2_points_r <= pwdata[3:0];
          cnt_r <= '0;
          sum_r <= '0;
          valid_r <= 1'b0;
        end else begin
          window_enable_r <= pwdata[0];
        end
      end
      unique case (state_r)
        S_LD_WR: begin
          valid_r <= 1'b0;
          sum_r <= sum_r + 22'(mv);
          cnt_r <= cnt_r + 1'b1;
        end
        S_LD_DC: begin
          sum_r <= '0;
          cnt_r <= '0;
          wcnt_r <= '0;
        end
        S_WN_WR: begin
          wcnt_r <= wcnt_r + 1'b1;
          j_r <= '0;
          s_r <= SW'(1);
        end
        S_BF_WB: begin
          if (bf_last) begin
            j_r <= '0;
            if (stage_last) valid_r <= 1'b1;
            else s_r <= s_r + 1'b1;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_RD_SQ3: rcnt_r <= '0;
        S_RD_ROOT: rcnt_r <= rcnt_r + 1'b1;
        default: ;
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    mul_r <= 66'(mul_a * mul_b);
    if (accept) begin
      in_r <= in_item;
      hit_r <= valid_r && (13'(in_item.bin_index) < 13'(n_pts));
    end
    if (state_r == S_WN_RD) hann_q <= HANN_ROM[rev_addr(wcnt_r)];
    if (state_r == S_BF_RB) begin
      cos_q <= COS_ROM[tw_idx];
      sin_q <= SIN_ROM[tw_idx];
    end
    unique case (state_r)
      S_LD_MUL: mvp_r <= 28'(in_r.sample) * 28'(VREF_MV);
      S_LD_DC: dc_r <= 31'(({9'd0, sum_r, 8'd0} + 39'(n_pts >> 1)) >> lg);
      S_WN_SUB: x_r <= 33'(re_q) - $signed({2'b00, dc_r});
      S_BF_RA: begin
        br_r <= re_q;
        bi_r <= im_q;
      end
      S_BF_M1: begin
        ar_r <= re_q;
        ai_r <= im_q;
      end
      S_BF_M2: acc_r <= mul_r;
      S_BF_M3: acc_r <= acc_r + mul_r;
      S_BF_M4: begin
        tr_r <= rnd_tw(acc_r);
        acc_r <= mul_r;
      end
      S_BF_M5: acc_r <= acc_r - mul_r;
      S_BF_WA: ti_r <= ti_rnd;
      S_RD_SQ2: acc_r <= mul_r;
      S_RD_SQ3: begin
        rem_r <= 64'(acc_r + mul_r);
        root_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      S_RD_ROOT: begin
        // one result bit per cycle
        if (root_take) begin
          rem_r <= rem_r - root_try;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_RD_FIN: begin
        out_item_r.bin_echo <= in_r.bin_index;
        out_item_r.ready_res <= hit_r;
        if (!hit_r) out_item_r.magnitude <= '0;
        else if (root_fin > 33'(MAG_MAX)) out_item_r.magnitude <= 30'(MAG_MAX);
        else out_item_r.magnitude <= root_fin[29:0];
      end
      default: ;
    endcase
  end

  `FMS_ASSERT_IMP(a_out_when_idle, out_valid, !busy, "result strobe while busy")
  `FMS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `FMS_ASSERT_IMP(a_miss_zero, out_valid && !out_item.ready_res, out_item.magnitude == 30'd0, "not-ready result carries a magnitude")

endmodule
`default_nettype wire

/* bench/fft_magnitude_spectrum_top_test.sv */
`timescale 1ns / 1ps
module fft_magnitude_spectrum_top_test;
  import fms_pkg::*;

  localparam int PTS = 1024;
  localparam int TW_FRAC = 15;
  localparam int LIMIT_CYCLES = 3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fft_magnitude_spectrum_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // spectrum predictor state
  longint cos_tab[PTS];
  longint sin_tab[PTS];
  longint hann_tab[PTS];
  longint frame_re[PTS];
  longint frame_im[PTS];
  int unsigned frame_sum;
  int unsigned frame_count;
  bit frame_ready;
  int unsigned log2_cfg;
  bit window_cfg;

  in_item_t pending_beats[$];
  out_item_t expected_bins[$];
  int fail_count = 0;
  int idle_left = 0;
  bit quiet = 1'b0;
  int cycle_count = 0;

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -(64'sd1 <<< (bits - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint quantize_q30(longint q);
    return clip(rnd_shift(q, 31 - 16), 16);
  endfunction

  function automatic void build_trig_tables();
    longint unsigned quad, r4, th, t2, term;
    longint s, c, cv, sv, h;
    for (int k = 0; k < PTS; k++) begin
      quad = (4 * k) / PTS;
      r4 = (4 * k) % PTS;
      th = (PI_Q30 * r4) / (2 * PTS);
      t2 = (th * th) >> 30;
      s = 0;
      c = 0;
      term = th;
      for (int i = 0; i < 10; i++) begin
        if (i & 1) s -= longint'(term); else s += longint'(term);
        term = ((term * t2) >> 30) / ((2 * i + 2) * (2 * i + 3));
      end
      term = ONE_Q30;
      for (int i = 0; i < 10; i++) begin
        if (i & 1) c -= longint'(term); else c += longint'(term);
        term = ((term * t2) >> 30) / ((2 * i + 1) * (2 * i + 2));
      end
      case (quad & 3)
        0: begin cv = c; sv = s; end
        1: begin cv = -s; sv = c; end
        2: begin cv = -c; sv = -s; end
        default: begin cv = s; sv = -c; end
      endcase
      cos_tab[k] = quantize_q30(cv);
      sin_tab[k] = quantize_q30(sv);
      h = ONE_Q30 - cv;
      if (h < 0) h = 0;
      hann_tab[k] = quantize_q30(h >>> 1);
    end
  endfunction

  function automatic int eff_log2();
    if (log2_cfg < 1) return 1;
    if (log2_cfg > 10) return 10;
    return log2_cfg;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void run_fft();
    int lg, n, stride, half, step, rev, ia, ib;
    longint dc, x, t, wc, ws, br, bi, ar, ai, tr, ti;
    lg = eff_log2();
    n = 1 << lg;
    stride = PTS >> lg;
    dc = ((longint'(frame_sum) << 8) + n / 2) >>> lg;
    for (int i = 0; i < n; i++) begin
      x = frame_re[i] - dc;
      if (window_cfg) x = rnd_shift(x * hann_tab[i * stride], TW_FRAC);
      frame_re[i] = clip(x, 32);
      frame_im[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      rev = 0;
      for (int b = 0; b < lg; b++)
        if (i & (1 << b)) rev |= 1 << (lg - 1 - b);
      if (rev > i) begin
        t = frame_re[i];
        frame_re[i] = frame_re[rev];
        frame_re[rev] = t;
      end
    end
    for (int len = 2; len <= n; len <<= 1) begin
      half = len / 2;
      step = PTS / len;
      for (int base = 0; base < n; base += len) begin
        for (int k = 0; k < half; k++) begin
          ia = base + k;
          ib = ia + half;
          wc = cos_tab[k * step];
          ws = sin_tab[k * step];
          br = frame_re[ib];
          bi = frame_im[ib];
          ar = frame_re[ia];
          ai = frame_im[ia];
          tr = rnd_shift(wc * br + ws * bi, TW_FRAC);
          ti = rnd_shift(wc * bi - ws * br, TW_FRAC);
          frame_re[ia] = clip(ar + tr, 32);
          frame_im[ia] = clip(ai + ti, 32);
          frame_re[ib] = clip(ar - tr, 32);
          frame_im[ib] = clip(ai - ti, 32);
        end
      end
    end
  endfunction

  function automatic void predict_beat(in_item_t it);
    int unsigned n, mv;
    longint unsigned ar, ai, s, r;
    out_item_t res;
    n = 1 << eff_log2();
    if (it.mode == MODE_LOAD) begin
      mv = (VREF_MV * it.sample) / ADC_FULL;
      frame_ready = 1'b0;
      if (frame_count >= n) begin
        frame_count = 0;
        frame_sum = 0;
      end
      frame_re[frame_count] = longint'(mv) << 8;
      frame_im[frame_count] = 0;
      frame_sum = (frame_sum + mv) & 32'h3F_FFFF;
      frame_count++;
      if (frame_count >= n) begin
        run_fft();
        frame_ready = 1'b1;
        frame_count = 0;
        frame_sum = 0;
      end
    end else begin
      res = '0;
      res.bin_echo = it.bin_index;
      if (frame_ready && it.bin_index < n) begin
        ar = frame_re[it.bin_index] < 0 ? -frame_re[it.bin_index] : frame_re[it.bin_index];
        ai = frame_im[it.bin_index] < 0 ? -frame_im[it.bin_index] : frame_im[it.bin_index];
        s = ar * ar + ai * ai;
        r = int_sqrt(s);
        if (s > r * r + r) r++;
        if (r > MAG_MAX) r = MAG_MAX;
        res.magnitude = r[29:0];
        res.ready_res = 1'b1;
      end
      expected_bins.push_back(res);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_beat(in_item);
        void'(pending_beats.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        idle_left = $urandom_range(0, 9);
        start <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        start <= 1'b1;
        in_item <= pending_beats[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_bins.size() == 0) begin
        $display("%0t: unexpected bin result, actual %p", $time, out_item);
        fail_count++;
      end else begin
        if (out_item.magnitude !== expected_bins[0].magnitude ||
            out_item.bin_echo !== expected_bins[0].bin_echo ||
            out_item.ready_res !== expected_bins[0].ready_res) begin
          $display("%0t: bin result mismatch, expected %p, actual %p",
                   $time, expected_bins[0], out_item);
          fail_count++;
        end
        void'(expected_bins.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_beat(logic mode, logic [15:0] sample, logic [9:0] bin);
    in_item_t it;
    it.mode = mode;
    it.sample = sample;
    it.bin_index = bin;
    pending_beats.push_back(it);
  endtask

  task automatic drain();
    @(negedge clk);
    @(negedge clk);
    while (pending_beats.size() != 0 || expected_bins.size() != 0 || busy || start)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(logic reg_idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_LOG2_POINTS) begin
      log2_cfg = value & 32'hF;
      frame_count = 0;
      frame_sum = 0;
      frame_ready = 1'b0;
    end else begin
      window_cfg = value[0];
    end
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int random_beats;
    int n, loads;
    build_trig_tables();
    log2_cfg = LOG2_RESET;
    window_cfg = 1'b0;
    frame_sum = 0;
    frame_count = 0;
    frame_ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // small frame with extreme codes, reads before and after it completes
    reg_write(REG_LOG2_POINTS, 2);
    reg_write(REG_WINDOW_ENABLE, 0);
    push_beat(MODE_READ, 0, 0);
    push_beat(MODE_LOAD, 16'h0000, 0);
    push_beat(MODE_LOAD, 16'hFFFF, 0);
    push_beat(MODE_LOAD, 16'h0001, 0);
    push_beat(MODE_READ, 0, 1);
    push_beat(MODE_LOAD, 16'h8000, 0);
    for (int b = 0; b < 4; b++) push_beat(MODE_READ, 0, b);
    push_beat(MODE_READ, 0, 10'h3FF);
    push_beat(MODE_READ, 0, 4);
    push_beat(MODE_LOAD, 16'h1234, 0);
    push_beat(MODE_READ, 0, 0);
    drain();
    // size 0 acts as two points, windowed
    reg_write(REG_WINDOW_ENABLE, 1);
    reg_write(REG_LOG2_POINTS, 0);
    push_beat(MODE_LOAD, 16'hFFFF, 0);
    push_beat(MODE_LOAD, 16'h0000, 0);
    push_beat(MODE_READ, 0, 0);
    push_beat(MODE_READ, 0, 1);
    push_beat(MODE_READ, 0, 2);
    drain();
    // oversized setting acts as the full size: one large alternating frame
    reg_write(REG_LOG2_POINTS, 15);
    for (int i = 0; i < PTS; i++) push_beat(MODE_LOAD, (i & 1) ? 16'hFFFF : 16'h0000, 0);
    push_beat(MODE_READ, 0, 0);
    push_beat(MODE_READ, 0, 1);
    push_beat(MODE_READ, 0, 512);
    push_beat(MODE_READ, 0, 10'h3FF);
    drain();
    reg_write(REG_WINDOW_ENABLE, 0);
    push_beat(MODE_LOAD, 16'hFFFF, 0);
    push_beat(MODE_READ, 0, 0);
    drain();

    random_beats = 0;
    while (random_beats < 1000) begin
      if (random_beats > 850) quiet = 1'b1;
      reg_write(REG_LOG2_POINTS, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6));
      reg_write(REG_WINDOW_ENABLE, $urandom_range(0, 1));
      n = 1 << eff_log2();
      repeat ($urandom_range(1, 3)) begin
        // truncate some frames so that the next size write lands mid-frame
        loads = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < loads; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            push_beat(MODE_READ, 16'($urandom), 10'($urandom));
            random_beats++;
          end
          push_beat(MODE_LOAD, pick_sample(), 10'($urandom));
          random_beats++;
        end
        repeat ($urandom_range(3, 8)) begin
          if ($urandom_range(0, 4) == 0)
            push_beat(MODE_READ, 16'($urandom), 10'($urandom));
          else
            push_beat(MODE_READ, 16'($urandom), 10'($urandom_range(0, n - 1)));
          random_beats++;
        end
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            push_beat(1'($urandom), 16'($urandom), 10'($urandom));
            random_beats++;
          end
        end
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* fft_magnitude_spectrum_top.f */
+incdir+rtl
rtl/fms_pkg.sv
rtl/fft_magnitude_spectrum_top.sv
bench/fft_magnitude_spectrum_top_test.sv
